// ===== hw/rtl/stt_pkg.sv =====
`default_nettype none

package stt_pkg;

  // Character codes the scanner reacts to
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  // Longest legal char literal, opening quote included, before the closing quote
  localparam int unsigned CHAR_MAX_LEN = 3;

  // Result error codes
  localparam logic [1:0] ERR_NONE          = 2'd0;
  localparam logic [1:0] ERR_OPEN_STRING   = 2'd1;
  localparam logic [1:0] ERR_OPEN_CHAR     = 2'd2;
  localparam logic [1:0] ERR_CHAR_OVERFLOW = 2'd3;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [1:0]  err;
    logic        last;
  } token_rec_t;

  function automatic logic is_delim(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    case (b) inside
      CH_SPACE, CH_CR, CH_LF,
      "(", ")", "{", "}", "[", "]",
      "+", "-", "/", "*", "=",
      ",", ".", ";", ":": hit = 1'b1;
      default:           hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/source_text_tokenizer.sv =====
// source_text_tokenizer: scans a byte stream of source text and emits one
// record per finished token (start line, start column, length in bytes).
// Space, tab, CR and LF between tokens are skipped; only a skipped LF bumps
// the line. Words end at a delimiter, every non-space delimiter is a token
// of its own, and quoted strings / chars run to their closing quote. An
// overlong char or a literal still open at source_end gives an error record
// and the block then swallows all further bytes until reset. Rate: one byte
// per clock while in_stall_o is low. The scan state is updated once per
// accepted byte; a byte can yield two records (a word closed by a one-byte
// delimiter), so results go through a registered 4-entry queue and
// in_stall_o rises when fewer than two entries are free. Output drains one
// record per clock while out_stall_i is low, so the byte rate holds as long
// as the sink keeps up and text averages at most one token per byte.
`default_nettype none

module source_text_tokenizer
  import stt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        source_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      token_line_o,
  output logic [15:0]      token_column_o,
  output logic [15:0]      token_length_o,
  output logic [1:0]       error_code_o,
  output logic             run_last_o
);

  localparam int unsigned W  = COUNT_WIDTH;
  localparam int unsigned XW = (W > 16) ? W : 16;

  // scan modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_WORD   = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;
  localparam logic [1:0] MODE_CHAR   = 2'd3;

  function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
    return (v == {W{1'b1}}) ? v : v + W'(1);
  endfunction

  function automatic logic [15:0] clamp16(input logic [W-1:0] v);
    logic [XW-1:0] x;
    x = XW'(v);
    return (x > XW'(16'hFFFF)) ? 16'hFFFF : x[15:0];
  endfunction

  function automatic token_rec_t make_rec(input logic [W-1:0] ln,
                                          input logic [W-1:0] col,
                                          input logic [W-1:0] len,
                                          input logic [1:0]   err);
    token_rec_t r;
    r.line   = clamp16(ln);
    r.column = clamp16(col);
    r.length = clamp16(len);
    r.err    = err;
    r.last   = 1'b0;
    return r;
  endfunction

  // scan state
  logic [1:0]   mode_q, mode_d;
  logic [W-1:0] line_q, line_d;
  logic [W-1:0] col_q, col_d;
  logic [W-1:0] start_line_q, start_line_d;
  logic [W-1:0] start_col_q, start_col_d;
  logic [W-1:0] len_q, len_d;
  logic         halted_q, halted_d;

  // result queue
  token_rec_t           fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]     cnt_q;

  logic       in_acc, out_pop;
  logic [1:0] push_n;
  token_rec_t res_a, res_b;

  assign in_stall_o = (cnt_q > (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_pop    = out_valid_o && !out_stall_i;

  // next scan state and the records this byte produces
  always_comb begin
    logic as_idle;
    logic err_stop;
    logic line_reset;
    token_rec_t rec;

    mode_d       = mode_q;
    line_d       = line_q;
    col_d        = col_q;
    start_line_d = start_line_q;
    start_col_d  = start_col_q;
    len_d        = len_q;
    halted_d     = halted_q;
    push_n       = 2'd0;
    res_a        = '0;
    res_b        = '0;
    as_idle      = 1'b0;
    err_stop     = 1'b0;
    line_reset   = 1'b0;
    rec          = '0;

    if (in_acc && !halted_q) begin
      unique case (mode_q)
        MODE_WORD: begin
          if (is_delim(text_byte_i)) begin
            res_a   = make_rec(start_line_q, start_col_q, len_q, ERR_NONE);
            push_n  = 2'd1;
            mode_d  = MODE_IDLE;
            as_idle = 1'b1;
          end else begin
            len_d = sat_inc(len_q);
          end
        end
        MODE_STRING: begin
          len_d = sat_inc(len_q);
          if (text_byte_i == CH_DQUOTE) begin
            res_a  = make_rec(start_line_q, start_col_q, len_d, ERR_NONE);
            push_n = 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_CHAR: begin
          len_d = sat_inc(len_q);
          if (text_byte_i == CH_SQUOTE) begin
            if (len_q > W'(CHAR_MAX_LEN)) begin
              res_a    = make_rec(start_line_q, start_col_q, len_d, ERR_CHAR_OVERFLOW);
              push_n   = 2'd1;
              halted_d = 1'b1;
              err_stop = 1'b1;
            end else begin
              res_a  = make_rec(start_line_q, start_col_q, len_d, ERR_NONE);
              push_n = 2'd1;
              mode_d = MODE_IDLE;
            end
          end
        end
        default: as_idle = 1'b1;
      endcase

      if (as_idle) begin
        if (text_byte_i == CH_SPACE || text_byte_i == CH_TAB || text_byte_i == CH_CR) begin
          // skipped
        end else if (text_byte_i == CH_LF) begin
          line_d     = sat_inc(line_q);
          line_reset = 1'b1;
        end else if (text_byte_i == CH_DQUOTE || text_byte_i == CH_SQUOTE) begin
          mode_d       = (text_byte_i == CH_DQUOTE) ? MODE_STRING : MODE_CHAR;
          start_line_d = line_q;
          start_col_d  = col_q;
          len_d        = W'(1);
        end else if (is_delim(text_byte_i)) begin
          rec = make_rec(line_q, col_q, W'(1), ERR_NONE);
          if (push_n == 2'd0) res_a = rec;
          else                res_b = rec;
          push_n = push_n + 2'd1;
        end else begin
          mode_d       = MODE_WORD;
          start_line_d = line_q;
          start_col_d  = col_q;
          len_d        = W'(1);
        end
      end

      if (!err_stop) begin
        col_d = line_reset ? '0 : sat_inc(col_q);
      end

      // end of source: flush a word, flag an open literal, restart position unless halted
      if (source_end_i && !err_stop) begin
        if (mode_d != MODE_IDLE) begin
          rec = make_rec(start_line_d, start_col_d, len_d,
                         (mode_d == MODE_WORD)   ? ERR_NONE :
                         (mode_d == MODE_STRING) ? ERR_OPEN_STRING : ERR_OPEN_CHAR);
          if (push_n == 2'd0) res_a = rec;
          else                res_b = rec;
          push_n = push_n + 2'd1;
          if (mode_d != MODE_WORD) halted_d = 1'b1;
        end
        if (!halted_d) begin
          mode_d       = MODE_IDLE;
          line_d       = W'(1);
          col_d        = '0;
          start_line_d = W'(1);
          start_col_d  = '0;
          len_d        = '0;
        end
      end

      if (push_n == 2'd1) res_a.last = 1'b1;
      if (push_n == 2'd2) res_b.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      line_q       <= W'(1);
      col_q        <= '0;
      start_line_q <= W'(1);
      start_col_q  <= '0;
      len_q        <= '0;
      halted_q     <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      line_q       <= line_d;
      col_q        <= col_d;
      start_line_q <= start_line_d;
      start_col_q  <= start_col_d;
      len_q        <= len_d;
      halted_q     <= halted_d;
    end
  end

  // queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
      rd_ptr_q <= rd_ptr_q + FIFO_AW'(out_pop);
      cnt_q    <= cnt_q + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(out_pop);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) fifo_q[wr_ptr_q] <= res_a;
    if (push_n == 2'd2) fifo_q[wr_ptr_q + FIFO_AW'(1)] <= res_b;
  end

  assign token_line_o   = fifo_q[rd_ptr_q].line;
  assign token_column_o = fifo_q[rd_ptr_q].column;
  assign token_length_o = fifo_q[rd_ptr_q].length;
  assign error_code_o   = fifo_q[rd_ptr_q].err;
  assign run_last_o     = fifo_q[rd_ptr_q].last;

  // checks
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue over capacity");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt released without reset");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && halted_q) |-> (push_n == 2'd0))
    else $error("record produced while halted");

  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0 && res_a.err != ERR_NONE) |-> (push_n == 2'd1 && halted_d))
    else $error("error record not alone or block not halted");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0 && start_line_q != '0)
    else $error("line count reached zero");

endmodule

`default_nettype wire
